FILE: sv/assert_macros.svh
// assertion helpers shared by the rtl files
// each macro expects clk and rst_n in the scope where it is used
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// condition holds on every clock edge out of reset
`define GBCI_ASSERT_ALWAYS(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// consequent holds in the same cycle as the antecedent
`define GBCI_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// consequent holds in the cycle after the antecedent
`define GBCI_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

FILE: sv/gbci_pkg.sv
// ----------------------------------------------------------------------------
// gbci_pkg
// Types and constants for gyro bias calibration and rate integration.
// ----------------------------------------------------------------------------
`default_nettype none

package gbci_pkg;

  localparam int NAXES  = 3;
  localparam int RATE_W = 16;
  localparam int TIME_W = 32;
  localparam int DT_W   = 16;
  localparam int SUM_W  = 24;  // holds up to 255 full-scale samples
  localparam int OFFS_W = 24;  // bias in q8
  localparam int CORR_W = 25;  // rate q8 minus bias
  localparam int PROD_W = CORR_W + DT_W + 1;
  localparam int ACC_W  = 48;
  localparam int PH_W   = 2;

  // dividend of the bias division: sum magnitude with 8 fraction bits,
  // the magnitude stays below 2^(SUM_W-1) for up to 255 samples
  localparam int DIV_W  = SUM_W - 1 + 8;

  // result phase codes
  localparam logic [PH_W-1:0] PHASE_CAL   = 2'd0;
  localparam logic [PH_W-1:0] PHASE_PRIME = 2'd1;
  localparam logic [PH_W-1:0] PHASE_INTEG = 2'd2;

  typedef logic signed [RATE_W-1:0] rate_t;
  typedef logic signed [SUM_W-1:0]  sum_t;
  typedef logic signed [OFFS_W-1:0] offs_t;
  typedef logic signed [ACC_W-1:0]  acc_t;

  typedef rate_t [NAXES-1:0] rate_vec_t;
  typedef sum_t  [NAXES-1:0] sum_vec_t;
  typedef offs_t [NAXES-1:0] offs_vec_t;
  typedef acc_t  [NAXES-1:0] acc_vec_t;

  localparam acc_t ACC_MAX = {1'b0, {(ACC_W-1){1'b1}}};
  localparam acc_t ACC_MIN = {1'b1, {(ACC_W-1){1'b0}}};

endpackage

`default_nettype wire

FILE: sv/gbci_offset_div.sv
// ----------------------------------------------------------------------------
// gbci_offset_div
// Bias divider: sum * 256 / CAL_SAMPLES for all three axes, truncated towards
// zero, by a combinational reciprocal multiply, registered, axes in parallel.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module gbci_offset_div
  import gbci_pkg::*;
#(
  parameter int CAL_SAMPLES = 200
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      start_i,
  input  sum_vec_t  sum_i,
  output offs_vec_t offset_o
);

  // reciprocal of CAL_SAMPLES, exact for every dividend below 2^DIV_W
  localparam int ShiftL = $clog2(CAL_SAMPLES);
  localparam int RecipW = DIV_W + 1;
  localparam int ProdW  = DIV_W + RecipW;
  localparam longint unsigned RecipVal =
    ((64'd1 << (DIV_W + ShiftL)) + 64'(CAL_SAMPLES) - 64'd1) / 64'(CAL_SAMPLES);
  localparam logic [RecipW-1:0] Recip = RecipW'(RecipVal);

  offs_vec_t         offset_r;
  offs_vec_t         offset_nxt;
  logic [SUM_W-1:0]  sum_abs [NAXES];
  logic [DIV_W-1:0]  num     [NAXES];
  logic [ProdW-1:0]  prod    [NAXES];
  logic [OFFS_W-1:0] q_abs   [NAXES];

  assign offset_o = offset_r;

  // magnitude times 256 over CAL_SAMPLES, sign restored afterwards
  always_comb begin
    for (int i = 0; i < NAXES; i++) begin
      sum_abs[i]    = sum_i[i][SUM_W-1] ? (~sum_i[i] + 1'b1) : sum_i[i];
      num[i]        = {sum_abs[i][SUM_W-2:0], 8'h00};
      prod[i]       = num[i] * Recip;
      q_abs[i]      = prod[i][DIV_W+ShiftL +: OFFS_W];
      offset_nxt[i] = sum_i[i][SUM_W-1] ? offs_t'(-q_abs[i]) : offs_t'(q_abs[i]);
    end
  end

  // signed bias loaded with the sample that ends calibration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      offset_r <= '0;
    end else if (start_i) begin
      offset_r <= offset_nxt;
    end
  end

  `GBCI_ASSERT_NEXT(div_hold, !start_i, offset_r == $past(offset_r), "bias changed without a load")
  `GBCI_ASSERT_NEXT(div_sign, start_i, (offset_r[0] == '0) || (offset_r[0][OFFS_W-1] == $past(sum_i[0][SUM_W-1])), "bias sign differs from sum sign")
  `GBCI_ASSERT_NEXT(div_zero, start_i && (sum_i[0] == '0), offset_r[0] == '0, "zero sum gave a non-zero bias")

endmodule

`default_nettype wire

FILE: sv/gbci_axis.sv
// ----------------------------------------------------------------------------
// gbci_axis
// One axis of the integrator: bias-corrected q8 rate times elapsed ms,
// added to the angle with saturation at the 48-bit limits.
// ----------------------------------------------------------------------------
`default_nettype none

module gbci_axis
  import gbci_pkg::*;
(
  input  rate_t           rate_i,
  input  offs_t           offset_i,
  input  logic [DT_W-1:0] dt_i,
  input  acc_t            acc_i,
  output acc_t            acc_o
);

  logic signed [CORR_W-1:0] corr;
  logic signed [PROD_W-1:0] prod;
  logic signed [ACC_W:0]    sum;

  // corrected rate in q8
  assign corr = CORR_W'($signed({rate_i, 8'h00})) - CORR_W'(offset_i);

  // rate times elapsed time
  assign prod = PROD_W'(corr) * $signed({1'b0, dt_i});

  // saturating accumulate
  assign sum = (ACC_W+1)'(acc_i) + (ACC_W+1)'(prod);

  always_comb begin
    if (sum[ACC_W] != sum[ACC_W-1]) begin
      acc_o = sum[ACC_W] ? ACC_MIN : ACC_MAX;
    end else begin
      acc_o = sum[ACC_W-1:0];
    end
  end

endmodule

`default_nettype wire

FILE: sv/gyro_bias_calibrate_integrate_core.sv
// ----------------------------------------------------------------------------
// gyro_bias_calibrate_integrate_core
// Gyro bias calibration over the first CAL_SAMPLES samples, then bias
// correction and saturating per-axis integration of rate times elapsed ms.
//
//   channel | direction | handshake          | payload
//   --------+-----------+--------------------+---------------------------------
//   in_     | input     | in_valid/in_stall  | rate_x/y/z, time_ms, clear_after
//   out_    | output    | out_valid/out_stall| angle_x/y/z, phase
//
// One sample per cycle unless out_stall holds a pending result; each sample
// passes the input register, then the result register. The bias is set by a
// reciprocal multiply in the cycle of the sample after calibration, which adds
// no stall. Synchronous active-low reset clears all but the data registers; no
// clearing pass is needed. A result held by out_stall holds the input register,
// and in_stall then follows out_stall in the same cycle.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module gyro_bias_calibrate_integrate_core
  import gbci_pkg::*;
#(
  parameter int CAL_SAMPLES = 200
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic signed [RATE_W-1:0] in_rate_x,
  input  logic signed [RATE_W-1:0] in_rate_y,
  input  logic signed [RATE_W-1:0] in_rate_z,
  input  logic [TIME_W-1:0]        in_time_ms,
  input  logic                     in_clear_after,
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic signed [ACC_W-1:0]  out_angle_x,
  output logic signed [ACC_W-1:0]  out_angle_y,
  output logic signed [ACC_W-1:0]  out_angle_z,
  output logic [PH_W-1:0]          out_phase
);

  localparam int CntW = $clog2(CAL_SAMPLES + 2);
  localparam logic [CntW-1:0] CalCnt = CntW'(CAL_SAMPLES);

  // input register
  logic              s_full_r;
  rate_vec_t         s_rate_r;
  logic [TIME_W-1:0] s_time_r;
  logic              s_clear_r;

  // block state
  logic [CntW-1:0]   cnt_r, cnt_nxt;
  sum_vec_t          sum_r, sum_nxt;
  logic [TIME_W-1:0] last_time_r, last_time_nxt;
  logic              time_valid_r, time_valid_nxt;
  acc_vec_t          acc_r, acc_nxt;

  // result register
  logic              out_valid_r;
  acc_vec_t          out_angle_r;
  logic [PH_W-1:0]   out_phase_r;

  logic              adv;
  logic              div_start;
  offs_vec_t         offset;
  logic [TIME_W-1:0] dt_raw;
  logic [DT_W-1:0]   dt;
  acc_vec_t          acc_upd;
  acc_vec_t          acc_rep;
  logic [PH_W-1:0]   phase_nxt;

  // handshake
  assign adv       = s_full_r && (!out_valid_r || !out_stall);
  assign in_stall  = s_full_r && !adv;
  assign out_valid = out_valid_r;

  // input transfer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s_full_r <= 1'b0;
    end else if (in_valid && !in_stall) begin
      s_full_r <= 1'b1;
    end else if (adv) begin
      s_full_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      s_rate_r[0] <= in_rate_x;
      s_rate_r[1] <= in_rate_y;
      s_rate_r[2] <= in_rate_z;
      s_time_r    <= in_time_ms;
      s_clear_r   <= in_clear_after;
    end
  end

  // elapsed time, wrapping, clamped to 16 bits
  assign dt_raw = s_time_r - last_time_r;
  assign dt     = (|dt_raw[TIME_W-1:DT_W]) ? '1 : dt_raw[DT_W-1:0];

  // per-axis integrators
  for (genvar g = 0; g < NAXES; g++) begin : g_axis
    gbci_axis u_axis (
      .rate_i   (s_rate_r[g]),
      .offset_i (offset[g]),
      .dt_i     (dt),
      .acc_i    (acc_r[g]),
      .acc_o    (acc_upd[g])
    );
  end

  // bias divider
  gbci_offset_div #(
    .CAL_SAMPLES (CAL_SAMPLES)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start_i  (div_start),
    .sum_i    (sum_r),
    .offset_o (offset)
  );

  // phase sequencing and state update
  always_comb begin
    cnt_nxt        = cnt_r;
    sum_nxt        = sum_r;
    last_time_nxt  = last_time_r;
    time_valid_nxt = time_valid_r;
    acc_rep        = acc_r;
    acc_nxt        = acc_r;
    phase_nxt      = PHASE_CAL;
    div_start      = 1'b0;
    if (adv) begin
      if (cnt_r < CalCnt) begin
        for (int i = 0; i < NAXES; i++) begin
          sum_nxt[i] = sum_r[i] + SUM_W'(s_rate_r[i]);
        end
        cnt_nxt   = cnt_r + 1'b1;
        phase_nxt = PHASE_CAL;
      end else if (cnt_r == CalCnt) begin
        div_start = 1'b1;
        cnt_nxt   = cnt_r + 1'b1;
        phase_nxt = PHASE_PRIME;
      end else if (!time_valid_r) begin
        last_time_nxt  = s_time_r;
        time_valid_nxt = 1'b1;
        phase_nxt      = PHASE_PRIME;
      end else begin
        acc_rep       = acc_upd;
        last_time_nxt = s_time_r;
        phase_nxt     = PHASE_INTEG;
      end
      acc_nxt = s_clear_r ? '0 : acc_rep;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r        <= '0;
      sum_r        <= '0;
      last_time_r  <= '0;
      time_valid_r <= 1'b0;
      acc_r        <= '0;
    end else begin
      cnt_r        <= cnt_nxt;
      sum_r        <= sum_nxt;
      last_time_r  <= last_time_nxt;
      time_valid_r <= time_valid_nxt;
      acc_r        <= acc_nxt;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_angle_r <= acc_rep;
      out_phase_r <= phase_nxt;
    end
  end

  assign out_angle_x = out_angle_r[0];
  assign out_angle_y = out_angle_r[1];
  assign out_angle_z = out_angle_r[2];
  assign out_phase   = out_phase_r;

  `GBCI_ASSERT_ALWAYS(cal_count_bound, cnt_r <= CntW'(CAL_SAMPLES + 1), "calibration count past limit")
  `GBCI_ASSERT_SAME(integ_needs_time, adv && (phase_nxt == PHASE_INTEG), time_valid_r && (cnt_r == CntW'(CAL_SAMPLES + 1)), "integration without recorded time or bias")
  `GBCI_ASSERT_NEXT(clear_zeroes_acc, adv && s_clear_r, (acc_r[0] == '0) && (acc_r[1] == '0) && (acc_r[2] == '0), "accumulators not cleared after transfer")
  `GBCI_ASSERT_SAME(start_at_boundary, div_start, (cnt_r == CalCnt) && adv, "bias division started outside calibration end")

endmodule

`default_nettype wire

FILE: dv/tb_gyro_bias_calibrate_integrate_core.sv
// ----------------------------------------------------------------------------
// tb_gyro_bias_calibrate_integrate_core
// Self-checking bench for the gyro bias calibration and integration core.
// A queue of samples feeds a clocked driver. A cycle-free predictor computes
// the expected report for each input transfer, and a clocked monitor checks
// every output transfer field by field. The stimulus covers calibration
// extremes, the bias division and time priming, zero, clamped and wrapping
// elapsed times, saturation bursts on every axis, clears and random samples.
// Both sides idle at random, and the receiver holds off twice for a long
// stretch.
// ----------------------------------------------------------------------------

module tb_gyro_bias_calibrate_integrate_core;
  timeunit 1ns;
  timeprecision 1ps;

  import gbci_pkg::*;

  localparam int CAL_SAMPLES = 200;
  localparam int N_RANDOM = 860;
  localparam int BURST_LEN = 360;
  localparam int HOLD_CYCLES = 400;
  localparam int STALL_LIMIT = 3000;
  localparam int RATE_MAX = 32767;
  localparam int RATE_MIN = -32768;
  localparam logic [TIME_W-1:0] DT_CAP = (1 << DT_W) - 1;

  typedef struct packed {
    rate_t             rate_x;
    rate_t             rate_y;
    rate_t             rate_z;
    logic [TIME_W-1:0] time_ms;
    logic              clear_after;
  } gyro_sample_t;

  typedef struct packed {
    acc_t            angle_x;
    acc_t            angle_y;
    acc_t            angle_z;
    logic [PH_W-1:0] phase;
  } angle_report_t;

  logic                     clk = 1'b0;
  logic                     rst_n = 1'b0;
  logic                     in_valid = 1'b0;
  logic                     in_stall;
  logic signed [RATE_W-1:0] in_rate_x = '0;
  logic signed [RATE_W-1:0] in_rate_y = '0;
  logic signed [RATE_W-1:0] in_rate_z = '0;
  logic [TIME_W-1:0]        in_time_ms = '0;
  logic                     in_clear_after = 1'b0;
  logic                     out_valid;
  logic                     out_stall = 1'b0;
  logic signed [ACC_W-1:0]  out_angle_x;
  logic signed [ACC_W-1:0]  out_angle_y;
  logic signed [ACC_W-1:0]  out_angle_z;
  logic [PH_W-1:0]          out_phase;

  gyro_sample_t  sample_queue[$];
  angle_report_t expected_reports[$];
  gyro_sample_t  driven;

  // predictor state
  int unsigned       cal_taken = 0;
  longint            bias_sum[NAXES];
  longint            bias_q8[NAXES];
  longint            angle_track[NAXES];
  logic [TIME_W-1:0] last_stamp = '0;
  bit                time_primed = 1'b0;

  logic [TIME_W-1:0] stim_time = '0;
  int unsigned samples_total = 0;
  int unsigned samples_sent = 0;
  int unsigned reports_checked = 0;
  int unsigned fail_count = 0;
  int unsigned clamp_count = 0;
  int unsigned saturation_count = 0;
  int unsigned clear_count = 0;
  int unsigned in_gap = 0;
  int unsigned in_calm = 0;
  int unsigned stall_left = 0;
  int unsigned out_calm = 0;
  int unsigned hold_left = 0;
  int unsigned next_hold_at = 300;
  int unsigned stalled_cycles = 0;

  gyro_bias_calibrate_integrate_core #(
    .CAL_SAMPLES(CAL_SAMPLES)
  ) i_dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_rate_x     (in_rate_x),
    .in_rate_y     (in_rate_y),
    .in_rate_z     (in_rate_z),
    .in_time_ms    (in_time_ms),
    .in_clear_after(in_clear_after),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_angle_x   (out_angle_x),
    .out_angle_y   (out_angle_y),
    .out_angle_z   (out_angle_z),
    .out_phase     (out_phase)
  );

  // clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // idle length: mostly none or short, a few long, with calm stretches
  function automatic int unsigned idle_length(inout int unsigned calm_left);
    int unsigned r;
    if (calm_left > 0) begin
      calm_left--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 2) begin
      calm_left = $urandom_range(20, 80);
      return 0;
    end
    if (r < 55) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic int rand_rate();
    return int'($urandom_range(0, 65535)) - 32768;
  endfunction

  function automatic int rate_extreme();
    return $urandom_range(0, 1) ? RATE_MAX : RATE_MIN;
  endfunction

  function automatic int jitter(int span);
    return int'($urandom_range(0, 2 * span)) - span;
  endfunction

  task automatic add_sample(input int rx, input int ry, input int rz,
                            input logic [TIME_W-1:0] t, input bit clr);
    gyro_sample_t s;
    s.rate_x      = rate_t'(rx);
    s.rate_y      = rate_t'(ry);
    s.rate_z      = rate_t'(rz);
    s.time_ms     = t;
    s.clear_after = clr;
    sample_queue.push_back(s);
    stim_time = t;
  endtask

  // drive every axis to its limit, come back a little, then clear
  task automatic saturate_axes(input int dir);
    int k;
    int hi;
    int lo;
    hi = (dir > 0) ? RATE_MAX : RATE_MIN;
    lo = (dir > 0) ? RATE_MIN : RATE_MAX;
    for (k = 0; k < BURST_LEN; k++) begin
      add_sample(hi, lo, hi, stim_time + DT_CAP + ((k % 7 == 0) ? 1000 : 0), 1'b0);
    end
    add_sample(lo, hi, lo, stim_time + 500, 1'b0);
    add_sample(lo, hi, lo, stim_time + 500, 1'b1);
  endtask

  // expected report for one accepted sample, then state update
  task automatic predict_report(input gyro_sample_t s);
    longint            rate[NAXES];
    longint            corr;
    longint            total;
    logic [TIME_W-1:0] dt;
    angle_report_t     r;
    int                i;
    rate[0] = longint'($signed(s.rate_x));
    rate[1] = longint'($signed(s.rate_y));
    rate[2] = longint'($signed(s.rate_z));
    if (cal_taken < CAL_SAMPLES) begin
      for (i = 0; i < NAXES; i++) bias_sum[i] += rate[i];
      cal_taken++;
      r.phase = PHASE_CAL;
    end else if (cal_taken == CAL_SAMPLES) begin
      // bias in q8, truncated toward zero
      for (i = 0; i < NAXES; i++) bias_q8[i] = (bias_sum[i] * 256) / CAL_SAMPLES;
      cal_taken++;
      r.phase = PHASE_PRIME;
    end else if (!time_primed) begin
      last_stamp  = s.time_ms;
      time_primed = 1'b1;
      r.phase     = PHASE_PRIME;
    end else begin
      // wrapping elapsed time, clamped
      dt = s.time_ms - last_stamp;
      if (dt > DT_CAP) begin
        dt = DT_CAP;
        clamp_count++;
      end
      for (i = 0; i < NAXES; i++) begin
        corr  = rate[i] * 256 - bias_q8[i];
        total = angle_track[i] + corr * longint'(dt);
        if (total > longint'(ACC_MAX)) begin
          total = ACC_MAX;
          saturation_count++;
        end else if (total < longint'(ACC_MIN)) begin
          total = ACC_MIN;
          saturation_count++;
        end
        angle_track[i] = total;
      end
      last_stamp = s.time_ms;
      r.phase    = PHASE_INTEG;
    end
    r.angle_x = acc_t'(angle_track[0]);
    r.angle_y = acc_t'(angle_track[1]);
    r.angle_z = acc_t'(angle_track[2]);
    expected_reports.push_back(r);
    // clear after reporting
    if (s.clear_after) begin
      for (i = 0; i < NAXES; i++) angle_track[i] = 0;
      clear_count++;
    end
  endtask

  task automatic compare_field(input string field, input logic [ACC_W-1:0] want,
                               input logic [ACC_W-1:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", field, $signed(want), $signed(got));
      fail_count++;
    end
  endtask

  // driver: one sample per transfer, random gaps between them
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        predict_report(driven);
        samples_sent++;
      end
      if (!in_valid || !in_stall) begin
        if (in_gap > 0) begin
          in_gap--;
          in_valid <= 1'b0;
        end else if (sample_queue.size() != 0) begin
          driven = sample_queue.pop_front();
          in_rate_x      <= driven.rate_x;
          in_rate_y      <= driven.rate_y;
          in_rate_z      <= driven.rate_z;
          in_time_ms     <= driven.time_ms;
          in_clear_after <= driven.clear_after;
          in_valid       <= 1'b1;
          in_gap = idle_length(in_calm);
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // monitor: check each result transfer, drive the receiver stall
  always @(posedge clk) begin
    angle_report_t want;
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        if (expected_reports.size() == 0) begin
          $error("result transfer with no expected report");
          fail_count++;
        end else begin
          want = expected_reports.pop_front();
          compare_field("angle_x", want.angle_x, out_angle_x);
          compare_field("angle_y", want.angle_y, out_angle_y);
          compare_field("angle_z", want.angle_z, out_angle_z);
          compare_field("phase", ACC_W'(want.phase), ACC_W'(out_phase));
        end
        reports_checked++;
      end
      // long hold-off so the core fills up and stalls its input
      if (hold_left == 0 && reports_checked >= next_hold_at) begin
        hold_left = HOLD_CYCLES;
        next_hold_at += 1000;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else if (stall_left > 0) begin
        stall_left--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
        stall_left = idle_length(out_calm);
      end
    end
  end

  // watchdog on cycles without any transfer
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
        stalled_cycles <= 0;
      end else if (stalled_cycles == STALL_LIMIT) begin
        $display("timeout: no transfer for %0d cycles", STALL_LIMIT);
        $display("Mismatches found");
        $finish;
      end else begin
        stalled_cycles <= stalled_cycles + 1;
      end
    end
  end

  initial begin
    int                bias[NAXES];
    int                k;
    int                r;
    int                rx;
    int                ry;
    int                rz;
    logic [TIME_W-1:0] t;
    for (k = 0; k < NAXES; k++) begin
      bias_sum[k]    = 0;
      bias_q8[k]     = 0;
      angle_track[k] = 0;
    end

    // calibration: extremes first, then noisy samples around a bias
    add_sample(RATE_MAX, RATE_MIN, 0, $urandom, 1'b0);
    add_sample(RATE_MIN, RATE_MAX, -1, $urandom, 1'b1);
    add_sample(RATE_MAX, RATE_MAX, RATE_MAX, $urandom, 1'b0);
    add_sample(RATE_MIN, RATE_MIN, RATE_MIN, $urandom, 1'b0);
    for (k = 0; k < NAXES; k++) bias[k] = int'($urandom_range(0, 8000)) - 4000;
    for (k = 4; k < CAL_SAMPLES; k++) begin
      add_sample(bias[0] + jitter(2000), bias[1] + jitter(2000), bias[2] + jitter(2000),
                 $urandom, 1'($urandom_range(0, 1)));
    end

    // bias division sample, then time priming
    add_sample(rand_rate(), rand_rate(), rand_rate(), $urandom, 1'b0);
    add_sample(rand_rate(), rand_rate(), rand_rate(), $urandom, 1'b0);

    // directed: zero, unit, full and clamped elapsed times, wrap, clears
    add_sample(RATE_MAX, RATE_MIN, 0, stim_time, 1'b0);
    add_sample(RATE_MAX, RATE_MIN, 1, stim_time + 1, 1'b0);
    add_sample(RATE_MIN, RATE_MAX, -1, stim_time + 1, 1'b0);
    add_sample(1000, -1000, 0, stim_time + DT_CAP, 1'b0);
    add_sample(-5, 5, RATE_MAX, stim_time + DT_CAP + 1, 1'b0);
    add_sample(RATE_MIN, RATE_MIN, RATE_MIN, stim_time + 100000, 1'b1);
    add_sample(0, 0, 0, stim_time + 10, 1'b0);
    add_sample(123, -456, 789, stim_time - 1, 1'b0);
    add_sample(RATE_MAX, RATE_MAX, RATE_MAX, 32'hFFFF_FFF0, 1'b0);
    add_sample(RATE_MIN, RATE_MIN, RATE_MIN, 32'h0000_0010, 1'b0);
    add_sample(rand_rate(), rand_rate(), rand_rate(), stim_time + 255, 1'b1);
    add_sample(rand_rate(), rand_rate(), rand_rate(), stim_time, 1'b1);
    add_sample(-1, 0, 1, stim_time + 1, 1'b0);
    add_sample(RATE_MAX, RATE_MIN, RATE_MAX, 32'h0000_0000, 1'b0);
    add_sample(RATE_MIN, RATE_MAX, RATE_MIN, 32'hFFFF_FFFF, 1'b1);

    // saturation on both limits of every axis
    saturate_axes(1);
    saturate_axes(-1);

    // random samples with mixed time steps
    for (k = 0; k < N_RANDOM; k++) begin
      rx = ($urandom_range(0, 9) == 0) ? rate_extreme() : rand_rate();
      ry = ($urandom_range(0, 9) == 0) ? rate_extreme() : rand_rate();
      rz = ($urandom_range(0, 9) == 0) ? rate_extreme() : rand_rate();
      r  = $urandom_range(0, 99);
      if (r < 60) t = stim_time + $urandom_range(0, 200);
      else if (r < 80) t = stim_time + $urandom_range(0, 65535);
      else if (r < 88) t = stim_time + $urandom_range(65536, 32'h7FFF_FFFF);
      else if (r < 93) t = stim_time;
      else if (r < 97) t = stim_time - $urandom_range(1, 1000);
      else t = $urandom;
      add_sample(rx, ry, rz, t, $urandom_range(0, 11) == 0);
    end
    samples_total = sample_queue.size();

    // reset
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // drain
    while (samples_sent != samples_total) @(posedge clk);
    while (expected_reports.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);

    $display("run: %0d samples in, %0d reports checked, %0d failures",
             samples_sent, reports_checked, fail_count);
    $display("covered: calibration, bias division, priming, %0d clamped steps, %0d saturations, %0d clears",
             clamp_count, saturation_count, clear_count);
    if (fail_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
